// ===== sv/prf_pkg.sv =====
package prf_pkg;

  localparam int NUM_COEF  = 6;
  localparam int COEF_W    = 16;
  localparam int DCOEF_W   = 20;
  localparam int DEG_W     = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 32;
  localparam int TOL_W     = 32;
  localparam int X_W       = 32;
  localparam int F_W       = 48;
  localparam int ITER_W    = 7;
  localparam int STATUS_W  = 2;
  localparam int A_W       = 48;
  localparam int B_W       = 33;
  localparam int C_W       = 49;
  localparam int P_W       = A_W + B_W;
  localparam int Q_W       = 51;
  localparam int SUM_W     = 53;
  localparam int MUL_DIGITS = 3;
  localparam int DIGIT_W   = 16;
  localparam int FRAC_W    = 16;
  localparam int HW_DEGREE = 5;

  localparam logic [CFG_IDX_W-1:0] REG_DEGREE = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_TOL    = 3'd7;

  localparam logic [STATUS_W-1:0] STATUS_CONVERGED = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_LIMIT     = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_ZERO_DIV  = 2'd2;

  localparam logic [Q_W-1:0] Q_CAP = {1'b1, {(Q_W-1){1'b0}}};

  typedef enum logic [2:0] {
    S_IDLE, S_H_INIT, S_H_MUL, S_H_WAIT, S_AFTER, S_LOOP, S_QUOT, S_FINISH
  } state_t;

  typedef enum logic [1:0] {PH_F0, PH_F1, PH_FD, PH_FNEW} phase_t;

  typedef enum logic [1:0] {MD_IDLE, MD_MUL, MD_DIV, MD_DONE} md_state_t;

  typedef struct packed {
    logic start;
    logic divide;
  } md_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } md_rsp_t;

endpackage

// ===== sv/prf_channels.sv =====
interface prf_in_if;
  import prf_pkg::*;
  logic                  valid;
  logic                  ready;
  logic                  action;
  logic signed [X_W-1:0] guess_a;
  logic signed [X_W-1:0] guess_b;
  modport source(output valid, action, guess_a, guess_b, input ready);
  modport sink(input valid, action, guess_a, guess_b, output ready);
endinterface

interface prf_out_if;
  import prf_pkg::*;
  logic                  valid;
  logic                  ready;
  logic signed [X_W-1:0] root;
  logic signed [F_W-1:0] residual;
  logic [ITER_W-1:0]     iterations;
  logic [STATUS_W-1:0]   status;
  modport source(output valid, root, residual, iterations, status, input ready);
  modport sink(input valid, root, residual, iterations, status, output ready);
endinterface

// ===== sv/prf_muldiv.sv =====
module prf_muldiv (
  input  logic                     clk,
  input  logic                     rst,
  input  prf_pkg::md_req_t         req,
  input  logic [prf_pkg::A_W-1:0]  a_mag,
  input  logic [prf_pkg::B_W-1:0]  b_mag,
  input  logic [prf_pkg::C_W-1:0]  c_mag,
  output prf_pkg::md_rsp_t         rsp,
  output logic [prf_pkg::Q_W-1:0]  quo
);
  import prf_pkg::*;

  localparam int CNT_W = $clog2(P_W);
  localparam int B_REG_W = MUL_DIGITS * DIGIT_W;

  md_state_t mstate, mstate_next;
  logic [A_W-1:0]     a;
  logic [B_REG_W-1:0] b;
  logic [C_W-1:0]     c;
  logic [P_W-1:0]     p, p_next;
  logic [CNT_W-1:0]   cnt;
  logic [C_W-1:0]     rem;
  logic               divide;

  logic [A_W+DIGIT_W-1:0] pp;
  logic [C_W:0]           rem_sh;
  logic [C_W:0]           rem_diff;
  logic                   ge;

  function automatic logic [Q_W-1:0] cap(input logic [P_W-1:0] v);
    return (v > P_W'(Q_CAP)) ? Q_CAP : v[Q_W-1:0];
  endfunction

  assign pp       = a * b[DIGIT_W-1:0];
  assign rem_sh   = {rem, p[P_W-1]};
  assign rem_diff = rem_sh - {1'b0, c};
  assign ge       = rem_sh >= {1'b0, c};

  always_comb begin
    p_next = p;
    if (mstate == MD_MUL) begin
      p_next = p + (P_W'(pp) << {cnt[1:0], 4'b0000});
    end else if (mstate == MD_DIV) begin
      p_next = {p[P_W-2:0], ge};
    end
  end

  always_comb begin
    mstate_next = mstate;
    unique case (mstate)
      MD_IDLE: if (req.start) mstate_next = MD_MUL;
      MD_MUL: begin
        if (cnt == CNT_W'(MUL_DIGITS - 1)) mstate_next = divide ? MD_DIV : MD_DONE;
      end
      MD_DIV: if (cnt == CNT_W'(P_W - 1)) mstate_next = MD_DONE;
      MD_DONE: mstate_next = MD_IDLE;
      default: mstate_next = MD_IDLE;
    endcase
  end

  always_comb begin
    rsp.busy = (mstate != MD_IDLE);
    rsp.done = (mstate == MD_DONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mstate <= MD_IDLE;
    end else begin
      mstate <= mstate_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (mstate)
      MD_IDLE: begin
        if (req.start) begin
          a      <= a_mag;
          b      <= B_REG_W'(b_mag);
          c      <= c_mag;
          p      <= '0;
          cnt    <= '0;
          divide <= req.divide;
        end
      end
      MD_MUL: begin
        p <= p_next;
        b <= b >> DIGIT_W;
        if (cnt == CNT_W'(MUL_DIGITS - 1)) begin
          cnt <= '0;
          rem <= '0;
          quo <= cap(P_W'(p_next[P_W-1:FRAC_W]));
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
      MD_DIV: begin
        p   <= p_next;
        rem <= ge ? rem_diff[C_W-1:0] : rem_sh[C_W-1:0];
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(P_W - 1)) quo <= cap(p_next);
      end
      MD_DONE: begin
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== sv/polynomial_root_finder_core.sv =====
// datapath: each horner step multiplies on the shared multiply unit, which also performs
//   the divides; an item runs newton or secant iterations for a polynomial of degree d,
//   up to MAX_ITER of them, with d at most 5
// throughput: one item at a time; ready stays low until the result sits in the output
//   register, which frees the input side while the result beat waits
// reset: synchronous, clears the sequencer and output valid, loads register defaults
module polynomial_root_finder_core #(
  parameter int MAX_DEGREE = 5,
  parameter int MAX_ITER   = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [prf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [prf_pkg::CFG_W-1:0]     cfg_data,
  prf_in_if.sink                        request,
  prf_out_if.source                     result
);
  import prf_pkg::*;

  localparam int IW   = $clog2(MAX_ITER + 1);
  localparam int DCAP = (MAX_DEGREE < HW_DEGREE) ? MAX_DEGREE : HW_DEGREE;
  localparam logic signed [SUM_W-1:0] F_MAX = SUM_W'(48'sh7FFF_FFFF_FFFF);
  localparam logic signed [SUM_W-1:0] F_MIN = -F_MAX - 1;
  localparam logic signed [SUM_W-1:0] X_MAX = SUM_W'(32'sh7FFF_FFFF);
  localparam logic signed [SUM_W-1:0] X_MIN = -X_MAX - 1;

  state_t state, state_next;
  phase_t phase;

  logic signed [COEF_W-1:0] coef [NUM_COEF];
  logic [DEG_W-1:0]         degree;
  logic [TOL_W-1:0]         tol;

  logic                  method;
  logic signed [X_W-1:0] x0, x1, hx;
  logic signed [F_W-1:0] f0, f1, acc;
  logic                  hderiv;
  logic [DEG_W-1:0]      hdeg, j;
  logic [IW-1:0]         iter;
  logic [STATUS_W-1:0]   status;
  logic                  md_neg;
  logic                  ovalid;

  md_req_t          md_req;
  md_rsp_t          md_rsp;
  logic [A_W-1:0]   md_a;
  logic [B_W-1:0]   md_b;
  logic [C_W-1:0]   md_c;
  logic [Q_W-1:0]   quo;

  logic [DEG_W-1:0]           d_eff;
  logic [DEG_W-1:0]           sel_idx;
  logic [DEG_W-1:0]           kidx;
  logic signed [COEF_W-1:0]   ck;
  logic signed [DCOEF_W-1:0]  cs;
  logic signed [SUM_W-1:0]    q_s, sum, xdiff;
  logic signed [F_W-1:0]      acc_sat;
  logic signed [X_W-1:0]      x2;
  logic [A_W-1:0]             acc_mag, f1_mag;
  logic [B_W-1:0]             hx_mag, dx_mag;
  logic signed [B_W-1:0]      dx;
  logic signed [C_W-1:0]      df;
  logic [C_W-1:0]             df_mag;
  logic                       conv;

  assign d_eff = (degree > DEG_W'(DCAP)) ? DEG_W'(DCAP) : degree;

  assign sel_idx = (state == S_H_INIT) ? hdeg : j - 1'b1;
  assign kidx    = hderiv ? sel_idx + 1'b1 : sel_idx;
  assign ck      = (kidx < DEG_W'(NUM_COEF)) ? coef[kidx] : '0;
  assign cs      = hderiv ? $signed({{(DCOEF_W-COEF_W){ck[COEF_W-1]}}, ck})
                            * $signed(DCOEF_W'(kidx))
                          : DCOEF_W'(ck);

  assign acc_mag = acc[F_W-1] ? A_W'(-acc) : A_W'(acc);
  assign f1_mag  = f1[F_W-1] ? A_W'(-f1) : A_W'(f1);
  assign hx_mag  = hx[X_W-1] ? B_W'(-$signed(B_W'(hx))) : B_W'(hx);
  assign dx      = $signed(B_W'(x1)) - $signed(B_W'(x0));
  assign dx_mag  = dx[B_W-1] ? B_W'(-dx) : B_W'(dx);
  assign df      = $signed(C_W'(f1)) - $signed(C_W'(f0));
  assign df_mag  = df[C_W-1] ? C_W'(-df) : C_W'(df);
  assign conv    = acc_mag <= A_W'(tol);

  assign q_s = md_neg ? (SUM_W'(0) - SUM_W'(quo)) : SUM_W'(quo);
  assign sum = $signed({{(SUM_W-DCOEF_W-FRAC_W){cs[DCOEF_W-1]}}, cs, 16'h0000}) + q_s;
  assign acc_sat = (sum > F_MAX) ? F_W'(F_MAX) : (sum < F_MIN) ? F_W'(F_MIN) : F_W'(sum);
  assign xdiff = $signed(SUM_W'(x1)) - q_s;
  assign x2 = (xdiff > X_MAX) ? X_W'(X_MAX) : (xdiff < X_MIN) ? X_W'(X_MIN) : X_W'(xdiff);

  assign request.ready     = (state == S_IDLE);
  assign result.valid      = ovalid;

  prf_muldiv u_muldiv (
    .clk   (clk),
    .rst   (rst),
    .req   (md_req),
    .a_mag (md_a),
    .b_mag (md_b),
    .c_mag (md_c),
    .rsp   (md_rsp),
    .quo   (quo)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (request.valid) state_next = S_H_INIT;
      S_H_INIT: state_next = S_H_MUL;
      S_H_MUL:  state_next = (j == '0) ? S_AFTER : S_H_WAIT;
      S_H_WAIT: if (md_rsp.done) state_next = S_H_MUL;
      S_AFTER: begin
        unique case (phase)
          PH_F0:   state_next = S_H_INIT;
          PH_F1:   state_next = S_LOOP;
          PH_FD:   state_next = (acc == '0) ? S_FINISH : S_QUOT;
          PH_FNEW: state_next = (conv || iter == IW'(MAX_ITER)) ? S_FINISH : S_LOOP;
          default: state_next = S_FINISH;
        endcase
      end
      S_LOOP: begin
        if (!method) state_next = (d_eff == '0) ? S_FINISH : S_H_INIT;
        else         state_next = (df == '0) ? S_FINISH : S_QUOT;
      end
      S_QUOT:   if (md_rsp.done) state_next = S_H_INIT;
      S_FINISH: if (!ovalid || result.ready) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    md_req.start  = 1'b0;
    md_req.divide = 1'b0;
    md_a = acc_mag;
    md_b = hx_mag;
    md_c = '0;
    if (state == S_H_MUL && j != '0) begin
      md_req.start = 1'b1;
    end else if (state == S_AFTER && phase == PH_FD && acc != '0) begin
      md_req.start  = 1'b1;
      md_req.divide = 1'b1;
      md_a = f1_mag;
      md_b = B_W'(1 << FRAC_W);
      md_c = C_W'(acc_mag);
    end else if (state == S_LOOP && method && df != '0) begin
      md_req.start  = 1'b1;
      md_req.divide = 1'b1;
      md_a = f1_mag;
      md_b = dx_mag;
      md_c = df_mag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      ovalid <= 1'b0;
      for (int i = 0; i < NUM_COEF; i++) coef[i] <= '0;
      degree <= DEG_W'(1);
      tol    <= TOL_W'(1);
    end else begin
      state <= state_next;
      if (state == S_FINISH && (!ovalid || result.ready)) ovalid <= 1'b1;
      else if (result.ready) ovalid <= 1'b0;
      if (cfg_we) begin
        if (cfg_index < CFG_IDX_W'(NUM_COEF)) coef[cfg_index] <= cfg_data[COEF_W-1:0];
        else if (cfg_index == REG_DEGREE)     degree <= cfg_data[DEG_W-1:0];
        else if (cfg_index == REG_TOL)        tol <= cfg_data[TOL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (request.valid) begin
          method <= request.action;
          x0     <= request.guess_a;
          x1     <= request.action ? request.guess_b : request.guess_a;
          hx     <= request.guess_a;
          phase  <= request.action ? PH_F0 : PH_F1;
          hderiv <= 1'b0;
          hdeg   <= d_eff;
          iter   <= '0;
        end
      end
      S_H_INIT: begin
        acc <= $signed({{(F_W-DCOEF_W-FRAC_W){cs[DCOEF_W-1]}}, cs, 16'h0000});
        j   <= hdeg;
      end
      S_H_MUL: begin
        if (j != '0) md_neg <= acc[F_W-1] ^ hx[X_W-1];
      end
      S_H_WAIT: begin
        if (md_rsp.done) begin
          acc <= acc_sat;
          j   <= j - 1'b1;
        end
      end
      S_AFTER: begin
        unique case (phase)
          PH_F0: begin
            f0    <= acc;
            hx    <= x1;
            phase <= PH_F1;
          end
          PH_F1: f1 <= acc;
          PH_FD: begin
            if (acc == '0) status <= STATUS_ZERO_DIV;
            else           md_neg <= f1[F_W-1] ^ acc[F_W-1];
          end
          PH_FNEW: begin
            f1 <= acc;
            if (conv)                         status <= STATUS_CONVERGED;
            else if (iter == IW'(MAX_ITER))   status <= STATUS_LIMIT;
          end
          default: begin
          end
        endcase
      end
      S_LOOP: begin
        if (!method) begin
          if (d_eff == '0) begin
            status <= STATUS_ZERO_DIV;
          end else begin
            hx     <= x1;
            hderiv <= 1'b1;
            hdeg   <= d_eff - 1'b1;
            phase  <= PH_FD;
          end
        end else begin
          if (df == '0) status <= STATUS_ZERO_DIV;
          else          md_neg <= f1[F_W-1] ^ dx[B_W-1] ^ df[C_W-1];
        end
      end
      S_QUOT: begin
        if (md_rsp.done) begin
          if (method) begin
            x0 <= x1;
            f0 <= f1;
          end
          x1     <= x2;
          hx     <= x2;
          iter   <= iter + 1'b1;
          hderiv <= 1'b0;
          hdeg   <= d_eff;
          phase  <= PH_FNEW;
        end
      end
      S_FINISH: begin
        if (!ovalid || result.ready) begin
          result.root       <= x1;
          result.residual   <= f1;
          result.iterations <= ITER_W'(iter);
          result.status     <= status;
        end
      end
      default: begin
      end
    endcase
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    request.valid && request.ready |=> state == S_H_INIT)
    else $error("accepted beat did not start a search");

  a_iter_bound: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> iter <= IW'(MAX_ITER))
    else $error("iteration count beyond limit");

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    md_req.start |-> !md_rsp.busy)
    else $error("shared unit started while busy");

  a_done_expected: assert property (@(posedge clk) disable iff (rst)
    md_rsp.done |-> (state == S_H_WAIT || state == S_QUOT))
    else $error("shared unit finished with no waiting step");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import prf_pkg::*;

  typedef struct {
    logic                  action;
    logic signed [X_W-1:0] guess_a;
    logic signed [X_W-1:0] guess_b;
  } search_t;

  typedef struct {
    logic signed [X_W-1:0] root;
    logic signed [F_W-1:0] residual;
    logic [ITER_W-1:0]     iterations;
    logic [STATUS_W-1:0]   status;
  } outcome_t;

  localparam longint SAT_HI = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint SAT_LO = -SAT_HI - 1;
  localparam int     ITER_LIMIT = 64;
  localparam int     DEG_LIMIT  = 5;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  prf_in_if  req_ch();
  prf_out_if res_ch();

  polynomial_root_finder_core DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .request(req_ch), .result(res_ch)
  );

  search_t  pending[$];
  outcome_t expected_roots[$];
  int       errors;
  bit       calm;

  longint      coef_copy[NUM_COEF];
  bit [2:0]    degree_copy;
  bit [31:0]   tol_copy;

  function automatic longint sat48(longint v);
    if (v > SAT_HI) return SAT_HI;
    if (v < SAT_LO) return SAT_LO;
    return v;
  endfunction

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint magnitude(longint v);
    return v < 0 ? -v : v;
  endfunction

  // trunc(a*b/c) toward zero, exact product, quotient capped at 2^50
  function automatic longint mul_div(longint a, longint b, longint c);
    logic [127:0] ma, mb, mc, prod, quo;
    bit neg;
    ma = magnitude(a);
    mb = magnitude(b);
    mc = magnitude(c);
    prod = ma * mb;
    quo = prod / mc;
    if (quo > (128'd1 << 50)) quo = 128'd1 << 50;
    neg = ((a < 0) != (b < 0)) != (c < 0);
    return neg ? -longint'(quo[63:0]) : longint'(quo[63:0]);
  endfunction

  function automatic longint horner_eval(longint c[NUM_COEF], int d, longint x);
    longint acc;
    acc = sat48(c[d] * 65536);
    for (int j = d - 1; j >= 0; j--) acc = sat48(c[j] * 65536 + mul_div(acc, x, 65536));
    return acc;
  endfunction

  function automatic outcome_t find_root(search_t s);
    outcome_t o;
    longint der[NUM_COEF];
    longint x0, x1, x2, f, fd, f0, f1, df;
    int d, dd, iter;
    logic [STATUS_W-1:0] st;
    d = degree_copy > DEG_LIMIT ? DEG_LIMIT : degree_copy;
    dd = d > 0 ? d - 1 : 0;
    for (int k = 0; k < NUM_COEF; k++) der[k] = 0;
    for (int k = 1; k <= d; k++) der[k-1] = k * coef_copy[k];
    x0 = s.guess_a;
    x1 = s.guess_b;
    iter = 0;
    st = STATUS_LIMIT;
    if (!s.action) begin
      x1 = x0;
      while (iter < ITER_LIMIT) begin
        f = horner_eval(coef_copy, d, x1);
        fd = d > 0 ? horner_eval(der, dd, x1) : 0;
        if (fd == 0) begin
          st = STATUS_ZERO_DIV;
          break;
        end
        x1 = sat32(x1 - mul_div(f, 65536, fd));
        iter++;
        if (magnitude(horner_eval(coef_copy, d, x1)) <= longint'({32'd0, tol_copy})) begin
          st = STATUS_CONVERGED;
          break;
        end
      end
    end else begin
      while (iter < ITER_LIMIT) begin
        f1 = horner_eval(coef_copy, d, x1);
        f0 = horner_eval(coef_copy, d, x0);
        df = f1 - f0;
        if (df == 0) begin
          st = STATUS_ZERO_DIV;
          break;
        end
        x2 = sat32(x1 - mul_div(f1, x1 - x0, df));
        x0 = x1;
        x1 = x2;
        iter++;
        if (magnitude(horner_eval(coef_copy, d, x1)) <= longint'({32'd0, tol_copy})) begin
          st = STATUS_CONVERGED;
          break;
        end
      end
    end
    o.root = x1[31:0];
    o.residual = F_W'(horner_eval(coef_copy, d, x1));
    o.iterations = ITER_W'(iter);
    o.status = st;
    return o;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h want %0h", what, got, want);
    errors++;
  endtask

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // driver
  int      req_gap;
  search_t next_item;
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
      req_gap <= 0;
    end else begin
      if (req_ch.valid && req_ch.ready)
        expected_roots.push_back(find_root('{req_ch.action, req_ch.guess_a, req_ch.guess_b}));
      if (!req_ch.valid || req_ch.ready) begin
        if (req_gap > 0) begin
          req_gap <= req_gap - 1;
          req_ch.valid <= 1'b0;
        end else if (pending.size() > 0 && !calm && $urandom_range(0, 7) == 0) begin
          req_gap <= $urandom_range(1, 9);
          req_ch.valid <= 1'b0;
        end else if (pending.size() > 0) begin
          next_item = pending.pop_front();
          req_ch.valid <= 1'b1;
          req_ch.action <= next_item.action;
          req_ch.guess_a <= next_item.guess_a;
          req_ch.guess_b <= next_item.guess_b;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  int       res_gap;
  int       hold_cnt;
  int       results_seen;
  bit       held;
  outcome_t want;
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
      res_gap <= 0;
      hold_cnt <= 0;
      results_seen <= 0;
      held <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        results_seen <= results_seen + 1;
        if (expected_roots.size() == 0) begin
          report("unexpected beat", res_ch.root, 0);
        end else begin
          want = expected_roots.pop_front();
          if (res_ch.root !== want.root) report("root", res_ch.root, want.root);
          if (res_ch.residual !== want.residual)
            report("residual", res_ch.residual, want.residual);
          if (res_ch.iterations !== want.iterations)
            report("iterations", res_ch.iterations, want.iterations);
          if (res_ch.status !== want.status) report("status", res_ch.status, want.status);
        end
      end
      if (hold_cnt > 0) begin
        hold_cnt <= hold_cnt - 1;
        res_ch.ready <= 1'b0;
      end else if (results_seen == 45 && !held) begin
        held <= 1'b1;
        hold_cnt <= 20000;
        res_ch.ready <= 1'b0;
      end else if (res_gap > 0) begin
        res_gap <= res_gap - 1;
        res_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        res_gap <= $urandom_range(1, 9);
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    if (idx == REG_DEGREE) degree_copy = value[2:0];
    else if (idx == REG_TOL) tol_copy = value;
    else coef_copy[idx] = longint'($signed(value[15:0]));
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_poly(longint c[NUM_COEF], logic [2:0] deg, logic [31:0] tol);
    for (int k = 0; k < NUM_COEF; k++) write_reg(CFG_IDX_W'(k), CFG_W'(c[k]));
    write_reg(REG_DEGREE, CFG_W'(deg));
    write_reg(REG_TOL, tol);
  endtask

  task automatic add_search(logic act, logic [31:0] a, logic [31:0] b);
    pending.push_back('{act, a, b});
  endtask

  task automatic wait_idle();
    while (pending.size() > 0 || req_ch.valid || expected_roots.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_guess();
    if ($urandom_range(0, 2) == 0) return $urandom;
    return $signed($urandom_range(0, 16 << 16)) - (8 << 16);
  endfunction

  task automatic random_phase(int n, bit wide);
    longint c[NUM_COEF];
    logic [2:0] deg;
    logic [31:0] tol;
    for (int k = 0; k < NUM_COEF; k++)
      c[k] = wide ? longint'($signed($urandom_range(0, 65535) - 32768))
                  : longint'($urandom_range(0, 16)) - 8;
    deg = $urandom_range(0, 9) == 0 ? 3'($urandom_range(0, 7)) : 3'($urandom_range(1, 3));
    case ($urandom_range(0, 3))
      0: tol = $urandom;
      1: tol = 0;
      default: tol = $urandom_range(0, 4096);
    endcase
    set_poly(c, deg, tol);
    for (int i = 0; i < n; i++) add_search(1'($urandom_range(0, 1)), pick_guess(), pick_guess());
    wait_idle();
  endtask

  initial begin
    longint c[NUM_COEF];
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    req_ch.valid = 1'b0;
    req_ch.action = 1'b0;
    req_ch.guess_a = '0;
    req_ch.guess_b = '0;
    res_ch.ready = 1'b0;
    errors = 0;
    calm = 1'b0;
    for (int k = 0; k < NUM_COEF; k++) coef_copy[k] = 0;
    degree_copy = 1;
    tol_copy = 1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // reset defaults: zero polynomial
    add_search(1'b0, 32'h0001_0000, 0);
    add_search(1'b1, 32'h8000_0000, 32'h7FFF_FFFF);
    wait_idle();

    // x^2 - 2
    c = '{-2, 0, 1, 0, 0, 0};
    set_poly(c, 3'd2, 32'd64);
    add_search(1'b0, 32'h0001_0000, 0);
    add_search(1'b0, 32'h8000_0000, 32'hFFFF_FFFF);
    add_search(1'b0, 32'h7FFF_FFFF, 0);
    add_search(1'b0, 32'h0000_0000, 0);
    add_search(1'b1, 32'h0001_0000, 32'h0002_0000);
    add_search(1'b1, 32'h0003_0000, 32'h0003_0000);
    add_search(1'b1, 32'hFFFF_0000, 32'h0001_0000);
    add_search(1'b1, 32'h8000_0000, 32'h7FFF_FFFF);
    wait_idle();

    // constant polynomial
    c = '{5, 1, 1, 1, 1, 1};
    set_poly(c, 3'd0, 32'd0);
    add_search(1'b0, 32'h1234_5678, 0);
    add_search(1'b1, 32'h0000_0000, 32'h0001_0000);
    wait_idle();

    // extreme coefficients, degree above the limit
    c = '{-32768, 32767, -32768, 32767, -32768, 32767};
    set_poly(c, 3'd7, 32'hFFFF_FFFF);
    add_search(1'b0, 32'h0000_8000, 0);
    add_search(1'b1, 32'h8000_0000, 32'h7FFF_FFFF);
    wait_idle();
    write_reg(REG_TOL, 32'd0);
    write_reg(REG_DEGREE, CFG_W'(3'd5));
    add_search(1'b0, 32'hFFFF_0000, 0);
    add_search(1'b1, 32'h0001_0000, 32'h0000_0001);
    wait_idle();

    random_phase(25, 1'b0);
    random_phase(25, 1'b0);
    random_phase(20, 1'b1);
    random_phase(25, 1'b0);
    random_phase(20, 1'b0);
    calm = 1'b1;
    random_phase(20, 1'b0);

    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    #300_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

// ===== polynomial_root_finder_core.f =====
sv/prf_pkg.sv
sv/prf_channels.sv
sv/prf_muldiv.sv
sv/polynomial_root_finder_core.sv
tb/tb.sv
